// ===== hw/rtl/bmm_pkg.sv =====
// Package for the bipartite matching block: default sizes, request codes
// and configuration register indexes. No dependencies.
package bmm_pkg;

	localparam int DEF_MAX_LEFT  = 256;
	localparam int DEF_MAX_RIGHT = 256;
	localparam int DEF_MAX_EDGES = 16384;

	localparam int CFG_W = 9;

	localparam logic [1:0] REQ_ADD     = 2'd0;
	localparam logic [1:0] REQ_COMPUTE = 2'd1;
	localparam logic [1:0] REQ_CLEAR   = 2'd2;

	localparam logic REG_LEFT_COUNT  = 1'b0;
	localparam logic REG_RIGHT_COUNT = 1'b1;

endpackage

// ===== hw/rtl/bipartite_max_matching.sv =====
// Maximum bipartite matching engine built around on-chip adjacency, owner,
// visit-mark and search-stack memories. Depends on bmm_pkg.

// Users start one word at a time with start while busy is low. An add-edge word
// leaves busy low and back-to-back adds run at one per cycle; a clear word
// keeps busy high while the list heads are swept, and after reset the same
// sweep runs before the first word. A compute word first sweeps the owner and
// visit memories, then runs one depth-first augmenting search per left vertex;
// each edge examined, each backtrack out of a dead-end vertex and each unwound
// path step costs memory round trips, so the run time follows the graph. The
// single result word is shown for one cycle with result_valid and cannot be
// held off by the receiver.
module bipartite_max_matching #(
	parameter int MAX_LEFT  = bmm_pkg::DEF_MAX_LEFT,
	parameter int MAX_RIGHT = bmm_pkg::DEF_MAX_RIGHT,
	parameter int MAX_EDGES = bmm_pkg::DEF_MAX_EDGES
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               req_type,
	input  logic [7:0]               left_vertex,
	input  logic [7:0]               right_vertex,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [bmm_pkg::CFG_W-1:0] cfg_wdata,
	output logic                     result_valid,
	output logic [8:0]               matching_size,
	output logic                     edges_dropped
);

	localparam int LW   = $clog2(MAX_LEFT);
	localparam int RW   = $clog2(MAX_RIGHT);
	localparam int EW   = $clog2(MAX_EDGES);
	localparam int EPW  = $clog2(MAX_EDGES + 1);
	localparam int SMAX = (MAX_LEFT > MAX_RIGHT) ? MAX_LEFT : MAX_RIGHT;
	localparam int SW   = $clog2(SMAX);
	localparam int LCW  = (LW + 1 > 9) ? LW + 1 : 9;
	localparam int RCW  = (RW + 1 > 9) ? RW + 1 : 9;
	localparam int TW   = LW + 1;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_HCLR   = 4'd1;
	localparam logic [3:0] ST_CLRPRE = 4'd2;
	localparam logic [3:0] ST_CSWP   = 4'd3;
	localparam logic [3:0] ST_NEXT   = 4'd4;
	localparam logic [3:0] ST_HEAD   = 4'd5;
	localparam logic [3:0] ST_EVAL   = 4'd6;
	localparam logic [3:0] ST_POP    = 4'd7;
	localparam logic [3:0] ST_ADV    = 4'd8;
	localparam logic [3:0] ST_EDGE   = 4'd9;
	localparam logic [3:0] ST_OWN    = 4'd10;
	localparam logic [3:0] ST_VIS    = 4'd11;
	localparam logic [3:0] ST_UN1    = 4'd12;
	localparam logic [3:0] ST_UN2    = 4'd13;
	localparam logic [3:0] ST_DONE   = 4'd14;

	// Memories.
	logic [EPW-1:0]      head_mem  [MAX_LEFT];
	logic [EPW+RW-1:0]   edge_mem  [MAX_EDGES];
	logic [LW:0]         owner_mem [MAX_RIGHT];
	logic [TW-1:0]       visit_mem [MAX_LEFT];
	logic [LW+EPW-1:0]   stack_mem [MAX_LEFT];

	logic              hd_we;
	logic [LW-1:0]     hd_wa, hd_ra;
	logic [EPW-1:0]    hd_wd, hd_rdata_q;
	logic              em_we;
	logic [EW-1:0]     em_wa, em_ra;
	logic [EPW+RW-1:0] em_wd, em_rdata_q;
	logic              ow_we;
	logic [RW-1:0]     ow_wa, ow_ra;
	logic [LW:0]       ow_wd, ow_rdata_q;
	logic              vi_we;
	logic [LW-1:0]     vi_wa, vi_ra;
	logic [TW-1:0]     vi_wd, vi_rdata_q;
	logic              st_we;
	logic [LW-1:0]     st_wa, st_ra;
	logic [LW+EPW-1:0] st_wd, st_rdata_q;

	always_ff @(posedge clk) begin
		if (hd_we) head_mem[hd_wa] <= hd_wd;
		hd_rdata_q <= head_mem[hd_ra];
	end
	always_ff @(posedge clk) begin
		if (em_we) edge_mem[em_wa] <= em_wd;
		em_rdata_q <= edge_mem[em_ra];
	end
	always_ff @(posedge clk) begin
		if (ow_we) owner_mem[ow_wa] <= ow_wd;
		ow_rdata_q <= owner_mem[ow_ra];
	end
	always_ff @(posedge clk) begin
		if (vi_we) visit_mem[vi_wa] <= vi_wd;
		vi_rdata_q <= visit_mem[vi_ra];
	end
	always_ff @(posedge clk) begin
		if (st_we) stack_mem[st_wa] <= st_wd;
		st_rdata_q <= stack_mem[st_ra];
	end

	// Control and datapath registers.
	logic [3:0]     state_q;
	logic [SW-1:0]  swp_q;
	logic [8:0]     left_count_q, right_count_q;
	logic [EPW-1:0] edge_count_q;
	logic           drop_q;
	logic [LW:0]    ci_q, top_q, res_q;
	logic [LW-1:0]  cur_v_q, w_q, un_v_q;
	logic [EPW-1:0] cur_e_q, nxt_q;
	logic [RW-1:0]  tgt_q;
	logic [TW-1:0]  tag_q;
	logic           result_valid_q, dropped_q;
	logic [8:0]     size_q;

	// Add-edge commit stage.
	logic           add_s1, fwd_s1;
	logic [LW-1:0]  lv_s1;
	logic [RW-1:0]  rv_s1;
	logic [EW-1:0]  idx_s1;
	logic [EPW-1:0] fwdv_s1;

	logic           accept, add_ok, ci_ok, tgt_ok;
	logic [RW-1:0]  em_tgt;
	logic [EPW-1:0] em_next, st_edge, head_val;
	logic [LW-1:0]  st_vert;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign add_ok  = (LCW'(left_vertex) < LCW'(left_count_q)) &&
			(LCW'(left_vertex) < LCW'(MAX_LEFT)) &&
			(RCW'(right_vertex) < RCW'(right_count_q)) &&
			(RCW'(right_vertex) < RCW'(MAX_RIGHT)) &&
			(edge_count_q < EPW'(MAX_EDGES));
	assign ci_ok   = (LCW'(ci_q) < LCW'(left_count_q)) && (ci_q < (LW + 1)'(MAX_LEFT));
	assign em_tgt  = em_rdata_q[RW-1:0];
	assign em_next = em_rdata_q[EPW+RW-1:RW];
	assign tgt_ok  = (RCW'(em_tgt) < RCW'(right_count_q));
	assign st_edge = st_rdata_q[EPW-1:0];
	assign st_vert = st_rdata_q[LW+EPW-1:EPW];
	// A same-list add in the previous cycle has not reached the head memory yet.
	assign head_val = fwd_s1 ? fwdv_s1 : hd_rdata_q;

	always_comb begin
		hd_we = 1'b0;
		hd_wa = lv_s1;
		hd_wd = EPW'(idx_s1) + EPW'(1);
		hd_ra = LW'(left_vertex);
		em_we = add_s1;
		em_wa = idx_s1;
		em_wd = {head_val, rv_s1};
		em_ra = EW'(cur_e_q - EPW'(1));
		ow_we = 1'b0;
		ow_wa = tgt_q;
		ow_wd = {1'b0, cur_v_q};
		ow_ra = em_tgt;
		vi_we = 1'b0;
		vi_wa = w_q;
		vi_wd = tag_q;
		vi_ra = ow_rdata_q[LW-1:0];
		st_we = 1'b0;
		st_wa = LW'(top_q - (LW + 1)'(1));
		st_wd = {cur_v_q, cur_e_q};
		st_ra = LW'(top_q - (LW + 1)'(2));
		if (add_s1) begin
			hd_we = 1'b1;
		end
		unique case (state_q)
			ST_HCLR: begin
				hd_we = 1'b1;
				hd_wa = LW'(swp_q);
				hd_wd = '0;
			end
			ST_CSWP: begin
				ow_we = (SW + 1)'(swp_q) < (SW + 1)'(MAX_RIGHT);
				ow_wa = RW'(swp_q);
				ow_wd = {1'b1, {LW{1'b0}}};
				vi_we = (SW + 1)'(swp_q) < (SW + 1)'(MAX_LEFT);
				vi_wa = LW'(swp_q);
				vi_wd = '0;
			end
			ST_NEXT: begin
				hd_ra = LW'(ci_q);
				vi_we = ci_ok;
				vi_wa = LW'(ci_q);
				vi_wd = TW'(ci_q) + TW'(1);
			end
			ST_POP: begin
				em_ra = EW'(st_edge - EPW'(1));
			end
			ST_OWN: begin
				ow_we = ow_rdata_q[LW];
			end
			ST_VIS: begin
				hd_ra = w_q;
				if (!(vi_rdata_q == tag_q || top_q >= (LW + 1)'(MAX_LEFT))) begin
					st_we = 1'b1;
					vi_we = 1'b1;
				end
			end
			ST_UN1: begin
				em_ra = EW'(st_edge - EPW'(1));
			end
			ST_UN2: begin
				ow_we = 1'b1;
				ow_wa = em_tgt;
				ow_wd = {1'b0, un_v_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_HCLR;
			swp_q          <= '0;
			left_count_q   <= 9'd256;
			right_count_q  <= 9'd256;
			edge_count_q   <= '0;
			drop_q         <= 1'b0;
			add_s1         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			add_s1         <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					bmm_pkg::REG_LEFT_COUNT:  left_count_q  <= cfg_wdata;
					bmm_pkg::REG_RIGHT_COUNT: right_count_q <= cfg_wdata;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req_type)
							bmm_pkg::REQ_ADD: begin
								if (add_ok) begin
									add_s1       <= 1'b1;
									lv_s1        <= LW'(left_vertex);
									rv_s1        <= RW'(right_vertex);
									idx_s1       <= EW'(edge_count_q);
									fwd_s1       <= add_s1 && (lv_s1 == LW'(left_vertex));
									fwdv_s1      <= EPW'(idx_s1) + EPW'(1);
									edge_count_q <= edge_count_q + EPW'(1);
								end else begin
									drop_q <= 1'b1;
								end
							end
							bmm_pkg::REQ_COMPUTE: begin
								swp_q   <= '0;
								state_q <= ST_CSWP;
							end
							bmm_pkg::REQ_CLEAR: begin
								edge_count_q <= '0;
								drop_q       <= 1'b0;
								state_q      <= ST_CLRPRE;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLRPRE: begin
					swp_q   <= '0;
					state_q <= ST_HCLR;
				end
				ST_HCLR: begin
					swp_q <= swp_q + SW'(1);
					if (LW'(swp_q) == LW'(MAX_LEFT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CSWP: begin
					swp_q <= swp_q + SW'(1);
					if (swp_q == SW'(SMAX - 1)) begin
						ci_q    <= '0;
						res_q   <= '0;
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (ci_ok) begin
						cur_v_q <= LW'(ci_q);
						tag_q   <= TW'(ci_q) + TW'(1);
						top_q   <= (LW + 1)'(1);
						state_q <= ST_HEAD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_HEAD: begin
					cur_e_q <= hd_rdata_q;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (cur_e_q == '0) begin
						if (top_q == (LW + 1)'(1)) begin
							ci_q    <= ci_q + (LW + 1)'(1);
							state_q <= ST_NEXT;
						end else begin
							top_q   <= top_q - (LW + 1)'(1);
							state_q <= ST_POP;
						end
					end else begin
						state_q <= ST_EDGE;
					end
				end
				ST_POP: begin
					cur_v_q <= st_vert;
					cur_e_q <= st_edge;
					state_q <= ST_ADV;
				end
				ST_ADV: begin
					cur_e_q <= em_next;
					state_q <= ST_EVAL;
				end
				ST_EDGE: begin
					tgt_q <= em_tgt;
					nxt_q <= em_next;
					if (tgt_ok) begin
						state_q <= ST_OWN;
					end else begin
						cur_e_q <= em_next;
						state_q <= ST_EVAL;
					end
				end
				ST_OWN: begin
					if (ow_rdata_q[LW]) begin
						// Free right vertex: flip owners back along the stack.
						if (top_q == (LW + 1)'(1)) begin
							res_q   <= res_q + (LW + 1)'(1);
							ci_q    <= ci_q + (LW + 1)'(1);
							state_q <= ST_NEXT;
						end else begin
							top_q   <= top_q - (LW + 1)'(1);
							state_q <= ST_UN1;
						end
					end else begin
						w_q     <= ow_rdata_q[LW-1:0];
						state_q <= ST_VIS;
					end
				end
				ST_VIS: begin
					if (vi_rdata_q == tag_q || top_q >= (LW + 1)'(MAX_LEFT)) begin
						cur_e_q <= nxt_q;
						state_q <= ST_EVAL;
					end else begin
						cur_v_q <= w_q;
						top_q   <= top_q + (LW + 1)'(1);
						state_q <= ST_HEAD;
					end
				end
				ST_UN1: begin
					un_v_q  <= st_vert;
					state_q <= ST_UN2;
				end
				ST_UN2: begin
					if (top_q == (LW + 1)'(1)) begin
						res_q   <= res_q + (LW + 1)'(1);
						ci_q    <= ci_q + (LW + 1)'(1);
						state_q <= ST_NEXT;
					end else begin
						top_q   <= top_q - (LW + 1)'(1);
						state_q <= ST_UN1;
					end
				end
				ST_DONE: begin
					result_valid_q <= 1'b1;
					size_q         <= 9'(res_q);
					dropped_q      <= drop_q;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid  = result_valid_q;
	assign matching_size = size_q;
	assign edges_dropped = dropped_q;

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_strobe_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result strobe without finished compute");

	a_stack_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> (top_q != '0 && top_q <= (LW + 1)'(MAX_LEFT)))
		else $error("search stack depth out of range");

endmodule

// ===== verif/tb_bipartite_max_matching.sv =====
// Self-checking testbench for bipartite_max_matching: directed table, then random
// graph traffic checked against a behavioral matching predictor.
// Depends on bmm_pkg and the bipartite_max_matching RTL.
module tb_bipartite_max_matching;

	localparam int NL = bmm_pkg::DEF_MAX_LEFT;
	localparam int NR = bmm_pkg::DEF_MAX_RIGHT;
	localparam int NE = bmm_pkg::DEF_MAX_EDGES;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam longint CYCLE_LIMIT = 40_000_000;
	localparam int RAND_WORDS = 1650;

	typedef struct packed {
		logic [8:0] size;
		logic       dropped;
	} match_res_t;

	typedef struct {
		bit         is_cfg;
		logic       idx;
		logic [8:0] val;
		logic [1:0] rq;
		logic [7:0] lv;
		logic [7:0] rv;
		bit         typed;
		logic [8:0] size;
		logic       dropped;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] req_type = bmm_pkg::REQ_ADD;
	logic [7:0] left_vertex = '0;
	logic [7:0] right_vertex = '0;
	logic cfg_we = 1'b0;
	logic cfg_index = bmm_pkg::REG_LEFT_COUNT;
	logic [bmm_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic result_valid;
	logic [8:0] matching_size;
	logic edges_dropped;

	bipartite_max_matching i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .left_vertex(left_vertex), .right_vertex(right_vertex),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.result_valid(result_valid), .matching_size(matching_size),
		.edges_dropped(edges_dropped)
	);

	always #6 clk = ~clk;

	// Graph shadow used for prediction.
	logic [14:0] g_head[NL];
	logic [14:0] g_next[NE];
	logic [7:0]  g_target[NE];
	int unsigned g_edges;
	int          g_owner[NR];
	bit          g_seen[NL];
	int          stk_vertex[NL];
	logic [14:0] stk_edge[NL];
	bit          g_drop;
	logic [8:0]  left_reg;
	logic [8:0]  right_reg;

	match_res_t exp_q[$];
	int errors = 0;
	int n_results = 0;
	int n_words = 0;
	int n_with_drop = 0;
	int burst_left = 0;
	longint cycles = 0;

	function automatic int clamp_lim(logic [8:0] r, int mx);
		return (r < mx) ? int'(r) : mx;
	endfunction

	function automatic bit find_augmenting(int src, int rlim);
		int top, k, v, w;
		for (int i = 0; i < NL; i++) g_seen[i] = 1'b0;
		g_seen[src] = 1'b1;
		stk_vertex[0] = src;
		stk_edge[0] = g_head[src];
		top = 1;
		while (top > 0) begin
			if (stk_edge[top-1] == 0) begin
				// Dead end: the parent frame advances past the edge it took.
				top--;
				if (top > 0) stk_edge[top-1] = g_next[stk_edge[top-1] - 1];
				continue;
			end
			k = stk_edge[top-1] - 1;
			v = g_target[k];
			if (v >= rlim) begin
				stk_edge[top-1] = g_next[k];
				continue;
			end
			w = g_owner[v];
			if (w < 0) begin
				while (top > 0) begin
					g_owner[g_target[stk_edge[top-1] - 1]] = stk_vertex[top-1];
					top--;
				end
				return 1'b1;
			end
			if (w >= NL || g_seen[w] || top >= NL) begin
				stk_edge[top-1] = g_next[k];
				continue;
			end
			g_seen[w] = 1'b1;
			stk_vertex[top] = w;
			stk_edge[top] = g_head[w];
			top++;
		end
		return 1'b0;
	endfunction

	function automatic logic [8:0] predict_matching();
		int llim, rlim, cnt;
		llim = clamp_lim(left_reg, NL);
		rlim = clamp_lim(right_reg, NR);
		cnt = 0;
		for (int i = 0; i < NR; i++) g_owner[i] = -1;
		for (int i = 0; i < llim; i++)
			if (find_augmenting(i, rlim)) cnt++;
		return cnt[8:0];
	endfunction

	function automatic void apply_word(logic [1:0] rq, logic [7:0] lv, logic [7:0] rv,
			bit typed, logic [8:0] size, logic dropped);
		match_res_t e;
		unique case (rq)
			bmm_pkg::REQ_ADD: begin
				if (lv >= clamp_lim(left_reg, NL) || rv >= clamp_lim(right_reg, NR) ||
						g_edges >= NE) begin
					g_drop = 1'b1;
				end else begin
					g_next[g_edges] = g_head[lv];
					g_target[g_edges] = rv;
					g_head[lv] = 15'(g_edges + 1);
					g_edges++;
				end
			end
			bmm_pkg::REQ_COMPUTE: begin
				e.size = predict_matching();
				e.dropped = g_drop;
				if (typed) begin
					e.size = size;
					e.dropped = dropped;
				end
				exp_q = {exp_q, e};
			end
			bmm_pkg::REQ_CLEAR: begin
				for (int i = 0; i < NL; i++) g_head[i] = '0;
				g_edges = 0;
				g_drop = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// Sender: random bursts, most of them preceded by a random gap; start stays high inside a burst.
	task automatic send_word(logic [1:0] rq, logic [7:0] lv, logic [7:0] rv,
			bit typed = 1'b0, logic [8:0] size = '0, logic dropped = 1'b0);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 6);
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		req_type <= rq;
		left_vertex <= lv;
		right_vertex <= rv;
		do @(posedge clk); while (busy);
		n_words++;
		apply_word(rq, lv, rv, typed, size, dropped);
	endtask

	// Waits until every expected word is back and the block is idle, plus a clear sweep.
	task automatic drain();
		start <= 1'b0;
		burst_left = 0;
		while (exp_q.size() != 0 || busy) @(posedge clk);
		repeat (NL + 40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [8:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bmm_pkg::REG_LEFT_COUNT) left_reg = val;
		else right_reg = val;
	endtask

	function automatic logic [8:0] pick_count();
		unique case ($urandom_range(0, 19))
			0: return 9'd0;
			1: return 9'd511;
			2: return 9'd256;
			3: return 9'd1;
			default: return 9'($urandom_range(2, 16));
		endcase
	endfunction

	function automatic logic [7:0] pick_vertex(logic [8:0] r, int mx);
		int lim;
		lim = clamp_lim(r, mx);
		if (lim == 0 || $urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, lim - 1));
	endfunction

	always @(posedge clk) begin
		match_res_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
		if (arst_n && result_valid) begin
			n_results++;
			if (exp_q.size() == 0) begin
				$display("%0t: unexpected word size=%0d dropped=%0b", $time,
					matching_size, edges_dropped);
				errors++;
			end else begin
				e = exp_q.pop_front();
				if (e.dropped) n_with_drop++;
				if (matching_size !== e.size) begin
					$display("%0t: matching_size expected %0d actual %0d", $time,
						e.size, matching_size);
					errors++;
				end
				if (edges_dropped !== e.dropped) begin
					$display("%0t: edges_dropped expected %0b actual %0b", $time,
						e.dropped, edges_dropped);
					errors++;
				end
			end
		end
	end

	dir_row_t dir_tab[] = '{
		'{0, 0, 0, bmm_pkg::REQ_COMPUTE, 0, 0, 1, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_ADD, 0, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_ADD, 255, 255, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_COMPUTE, 0, 0, 1, 2, 0},
		'{0, 0, 0, bmm_pkg::REQ_ADD, 0, 255, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_ADD, 255, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_COMPUTE, 0, 0, 0, 0, 0},
		'{0, 0, 0, REQ_UNUSED, 7, 7, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_COMPUTE, 0, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_CLEAR, 0, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_COMPUTE, 0, 0, 1, 0, 0},
		'{1, bmm_pkg::REG_LEFT_COUNT, 1, 0, 0, 0, 0, 0, 0},
		'{1, bmm_pkg::REG_RIGHT_COUNT, 1, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_ADD, 1, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_ADD, 0, 1, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_ADD, 0, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_COMPUTE, 0, 0, 1, 1, 1},
		'{0, 0, 0, bmm_pkg::REQ_CLEAR, 0, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_COMPUTE, 0, 0, 1, 0, 0},
		'{1, bmm_pkg::REG_LEFT_COUNT, 0, 0, 0, 0, 0, 0, 0},
		'{1, bmm_pkg::REG_RIGHT_COUNT, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_ADD, 0, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_COMPUTE, 0, 0, 1, 0, 1},
		'{1, bmm_pkg::REG_LEFT_COUNT, 511, 0, 0, 0, 0, 0, 0},
		'{1, bmm_pkg::REG_RIGHT_COUNT, 511, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_CLEAR, 0, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_ADD, 0, 1, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_ADD, 0, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_ADD, 1, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_COMPUTE, 0, 0, 1, 2, 0},
		'{0, 0, 0, bmm_pkg::REQ_ADD, 200, 200, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_ADD, 0, 200, 0, 0, 0},
		'{1, bmm_pkg::REG_LEFT_COUNT, 100, 0, 0, 0, 0, 0, 0},
		'{1, bmm_pkg::REG_RIGHT_COUNT, 100, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, bmm_pkg::REQ_COMPUTE, 0, 0, 0, 0, 0}
	};

	initial begin
		int rand_words, n_add;
		left_reg = 9'd256;
		right_reg = 9'd256;
		g_edges = 0;
		g_drop = 1'b0;
		for (int i = 0; i < NL; i++) g_head[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) write_reg(dir_tab[i].idx, dir_tab[i].val);
			else send_word(dir_tab[i].rq, dir_tab[i].lv, dir_tab[i].rv,
				dir_tab[i].typed, dir_tab[i].size, dir_tab[i].dropped);
		end

		rand_words = 0;
		while (rand_words < RAND_WORDS) begin
			if ($urandom_range(0, 3) == 0) begin
				write_reg(bmm_pkg::REG_LEFT_COUNT, pick_count());
				write_reg(bmm_pkg::REG_RIGHT_COUNT, pick_count());
			end
			if ($urandom_range(0, 2) == 0) begin
				send_word(bmm_pkg::REQ_CLEAR, 0, 0);
				rand_words++;
			end
			n_add = $urandom_range(1, 30);
			for (int i = 0; i < n_add; i++) begin
				if ($urandom_range(0, 29) == 0)
					send_word(REQ_UNUSED, 8'($urandom), 8'($urandom));
				send_word(bmm_pkg::REQ_ADD, pick_vertex(left_reg, NL),
					pick_vertex(right_reg, NR));
				rand_words++;
			end
			send_word(bmm_pkg::REQ_COMPUTE, 8'($urandom), 8'($urandom));
			rand_words++;
		end

		drain();
		$display("Sent %0d words; %0d matching results checked, %0d of them with dropped edges.",
			n_words, n_results, n_with_drop);
		$display("Covered empty graphs, zero and clamped counts, and late count changes.");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
